### hw/rtl/srrc_pkg.sv
// shared types, constants and helpers of the symbol rate register calculator
`default_nettype none

package srrc_pkg;

	localparam int RATE_W = 26;
	localparam int DIV_W = 28;
	localparam int STEP_W = 5;
	localparam int FIFO_DEPTH = 2;

	localparam logic [RATE_W-1:0] RATE_MIN = 26'd500000;
	localparam logic [RATE_W-1:0] RATE_MAX = 26'd46080000;
	localparam logic [RATE_W-1:0] RATE_SLOW = 26'd6000000;
	localparam logic [DIV_W-1:0] RATE_FIN = 28'd5760000;

	// floor(rate * 2^22 / 5760000) as floor(rate * RATIO_MUL / 2^38), exact for any 26-bit rate
	localparam logic [37:0] RATIO_MUL = 38'd200159983439;
	localparam logic [18:0] RATIO_MUL_LO = RATIO_MUL[18:0];
	localparam logic [18:0] RATIO_MUL_HI = RATIO_MUL[37:19];

	// 5760000 * 256 split into a preloaded remainder and 14 quotient steps
	localparam logic [DIV_W-1:0] BDRI_REM_INIT = 28'd90000;
	localparam logic [STEP_W-1:0] BDRI_STEPS = 5'd14;

	localparam logic [7:0] RATE_CTRL_RESET = 8'd43;
	localparam logic [7:0] ADC_BYPASS = 8'h89;
	localparam logic [7:0] ADC_FILTER = 8'h81;
	localparam logic [7:0] FILT_BASE = 8'h88;
	localparam logic [7:0] FILT_BYPASS = 8'h80;
	localparam logic [7:0] SLOW_BIT = 8'h80;
	localparam logic [7:0] FAST_MASK = 8'h7f;
	localparam logic [7:0] INV_SAT = 8'hff;

	localparam int NUM_FILT = 10;
	localparam logic [RATE_W-1:0] FNR_LIMIT [NUM_FILT] = '{
		26'd11184810, 26'd7381975, 26'd5592405, 26'd3728270, 26'd2796202,
		26'd1845493, 26'd1398101, 26'd905969, 26'd699050, 26'd459695
	};

	typedef struct packed {
		logic [RATE_W-1:0] symbol_rate;
		logic              clear_if_same;
	} in_item_t;

	typedef struct packed {
		logic              write_valid;
		logic              clear_request;
		logic [RATE_W-1:0] clamped_rate;
		logic [3:0]        filter_number;
		logic              bypass;
		logic [7:0]        adc_setting;
		logic [7:0]        filter_setting;
		logic [7:0]        rate_control;
		logic [19:0]       baud_increment;
		logic [7:0]        baud_inverse;
	} out_item_t;

	typedef struct packed {
		logic              same;
		logic              clr;
		logic [RATE_W-1:0] rate;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [RATE_W-1:0] dvd;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	// largest filter whose limit is above the ratio, bypass when none
	function automatic logic [4:0] filt_select(input logic [RATE_W-1:0] ratio);
		logic [3:0] fnr;
		logic       byp;
		fnr = 4'd0;
		byp = 1'b1;
		for (int i = 0; i < NUM_FILT; i++) begin
			if (ratio < FNR_LIMIT[i]) begin
				fnr = 4'(i);
				byp = 1'b0;
			end
		end
		return {byp, fnr};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/symbol_rate_register_calc.sv
// a changed rate passes the two-pass ratio multiply, filter choice and the 14-step serial
// divider for the inverse; an unchanged rate goes straight to the result register
// the back end takes the next rate only once the last is in the result register
// a two-entry queue lets the front accept items while the back end divides
// reset: last rate cleared to zero, rate control base set to 43, queue and output empty
`default_nettype none

module symbol_rate_register_calc #(
	parameter int FIFO_DEPTH = srrc_pkg::FIFO_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [7:0]           cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire srrc_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output srrc_pkg::out_item_t       out_data
);

	logic             fifo_full;
	logic             fifo_empty;
	logic             push;
	logic             pop;
	srrc_pkg::entry_t push_entry;
	srrc_pkg::entry_t head;

	srrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_entry (push_entry)
	);

	srrc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (fifo_full),
		.empty      (fifo_empty)
	);

	srrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head        (head),
		.empty       (fifo_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

### hw/rtl/srrc_front.sv
// front end: accepts items, compares with the last rate, clamps and stores it
`default_nettype none

module srrc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire srrc_pkg::in_item_t in_data,
	input  wire logic              fifo_full,
	output logic                   push,
	output srrc_pkg::entry_t       push_entry
);

	logic [srrc_pkg::RATE_W-1:0] last_rate_q;
	logic [srrc_pkg::RATE_W-1:0] clamped;
	logic                        same;

	assign in_stall = fifo_full;
	assign push = in_valid && !fifo_full;
	assign same = (in_data.symbol_rate == last_rate_q);

	always_comb begin
		clamped = in_data.symbol_rate;
		if (clamped > srrc_pkg::RATE_MAX)
			clamped = srrc_pkg::RATE_MAX;
		if (clamped < srrc_pkg::RATE_MIN)
			clamped = srrc_pkg::RATE_MIN;
	end

	always_comb begin
		push_entry.same = same;
		push_entry.clr = in_data.clear_if_same;
		push_entry.rate = clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rate_q <= '0;
		end else if (push && !same) begin
			last_rate_q <= clamped;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/srrc_fifo.sv
// short queue between front and back end
`default_nettype none

module srrc_fifo #(
	parameter int DEPTH = srrc_pkg::FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire srrc_pkg::entry_t push_entry,
	input  wire logic             pop,
	output srrc_pkg::entry_t      head,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	srrc_pkg::entry_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full)
			mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop && !empty)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if ((push && !full) && !(pop && !empty))
				count_q <= count_q + 1'b1;
			else if (!(push && !full) && (pop && !empty))
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/srrc_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module srrc_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srrc_pkg::div_req_t req,
	output logic                    done,
	output logic [srrc_pkg::RATE_W-1:0] quo
);

	logic                          busy_q;
	logic                          done_q;
	logic [srrc_pkg::STEP_W-1:0]   cnt_q;
	logic [srrc_pkg::DIV_W-1:0]    rem_q;
	logic [srrc_pkg::RATE_W-1:0]   dvd_q;
	logic [srrc_pkg::RATE_W-1:0]   quo_q;
	logic [srrc_pkg::DIV_W-1:0]    div_q;
	logic [srrc_pkg::DIV_W:0]      rem_sh;
	logic [srrc_pkg::DIV_W:0]      rem_sub;
	logic                          ge;

	assign rem_sh = {rem_q, dvd_q[srrc_pkg::RATE_W-1]};
	assign ge = (rem_sh >= {1'b0, div_q});
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == srrc_pkg::STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == srrc_pkg::STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dvd;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[srrc_pkg::DIV_W-1:0] : rem_sh[srrc_pkg::DIV_W-1:0];
			dvd_q <= {dvd_q[srrc_pkg::RATE_W-2:0], 1'b0};
			quo_q <= {quo_q[srrc_pkg::RATE_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

### hw/rtl/srrc_back.sv
// back end: ratio multiply, inverse division, filter choice and result register
`default_nettype none

module srrc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [7:0]          cfg_wr_data,
	input  wire srrc_pkg::entry_t    head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output srrc_pkg::out_item_t      out_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_SEL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                    state_q;
	logic [7:0]                    base_q;
	logic                          out_valid_q;
	srrc_pkg::out_item_t           out_data_q;
	logic                          same_q;
	logic                          clr_q;
	logic [srrc_pkg::RATE_W-1:0]   rate_q;
	logic [srrc_pkg::RATE_W-1:0]   ratio_lo_q;
	logic [srrc_pkg::RATE_W-1:0]   ratio_q;
	logic [3:0]                    fnr_q;
	logic                          byp_q;
	logic [2:0]                    sh_q;
	logic [19:0]                   bdr_q;
	logic [7:0]                    bdri_q;

	srrc_pkg::div_req_t            div_req;
	logic                          div_done;
	logic [srrc_pkg::RATE_W-1:0]   div_quo;

	logic [18:0]                   mul_k;
	logic [44:0]                   mul_prod;
	logic [44:0]                   ratio_acc;
	logic [4:0]                    sel;
	logic [2:0]                    sh;
	logic [29:0]                   ratio_sh;
	logic [26:0]                   bdr_rnd;
	logic [29:0]                   rate_sh;
	logic [14:0]                   inv_rnd;
	logic [13:0]                   inv_full;
	logic                          out_free;
	srrc_pkg::out_item_t           result;

	srrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ratio in two passes over the low and high halves of the reciprocal
	assign mul_k = (state_q == ST_MUL1) ? srrc_pkg::RATIO_MUL_LO : srrc_pkg::RATIO_MUL_HI;
	assign mul_prod = {19'b0, rate_q} * {26'b0, mul_k};
	assign ratio_acc = mul_prod + {19'b0, ratio_lo_q};

	assign sel = srrc_pkg::filt_select(ratio_q);
	assign sh = sel[3:1];
	assign ratio_sh = {4'b0, ratio_q} << sh;
	assign bdr_rnd = {1'b0, ratio_sh[29:4]} + 27'd1;
	assign rate_sh = {4'b0, rate_q} << sh;
	assign inv_rnd = {1'b0, div_quo[13:0]} + 15'd1;
	assign inv_full = inv_rnd[14:1];
	assign out_free = !out_valid_q || !out_stall;
	assign pop = (state_q == ST_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		div_req.start = 1'b0;
		div_req.rem_init = srrc_pkg::BDRI_REM_INIT;
		div_req.dvd = '0;
		div_req.steps = srrc_pkg::BDRI_STEPS;
		div_req.divisor = srrc_pkg::RATE_FIN;
		case (state_q)
			ST_SEL: begin
				div_req.start = 1'b1;
				div_req.rem_init = srrc_pkg::BDRI_REM_INIT;
				div_req.dvd = '0;
				div_req.steps = srrc_pkg::BDRI_STEPS;
				div_req.divisor = rate_sh[29:2];
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		result = '0;
		if (same_q) begin
			result.clear_request = clr_q;
		end else begin
			result.write_valid = 1'b1;
			result.clamped_rate = rate_q;
			result.filter_number = fnr_q;
			result.bypass = byp_q;
			result.adc_setting = byp_q ? srrc_pkg::ADC_BYPASS : srrc_pkg::ADC_FILTER;
			result.filter_setting = byp_q ? srrc_pkg::FILT_BYPASS :
				(srrc_pkg::FILT_BASE | {5'b0, sh_q} | {2'b0, fnr_q[0], 5'b0});
			result.rate_control = (rate_q < srrc_pkg::RATE_SLOW) ?
				(base_q | srrc_pkg::SLOW_BIT) : (base_q & srrc_pkg::FAST_MASK);
			result.baud_increment = bdr_q;
			result.baud_inverse = bdri_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q <= srrc_pkg::RATE_CTRL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				base_q <= cfg_wr_data;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty)
						state_q <= head.same ? ST_OUT : ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			same_q <= head.same;
			clr_q <= head.clr;
			rate_q <= head.rate;
		end
		if (state_q == ST_MUL1)
			ratio_lo_q <= mul_prod[44:19];
		if (state_q == ST_MUL2)
			ratio_q <= ratio_acc[44:19];
		if (state_q == ST_SEL) begin
			fnr_q <= sel[3:0];
			byp_q <= sel[4];
			sh_q <= sh;
			bdr_q <= bdr_rnd[20:1];
		end
		if (state_q == ST_DIV && div_done)
			bdri_q <= (|inv_full[13:8]) ? srrc_pkg::INV_SAT : inv_full[7:0];
		if (state_q == ST_OUT && out_free)
			out_data_q <= result;
	end

endmodule

`default_nettype wire

### bench/symbol_rate_register_calc_test.sv
// testbench for the symbol rate register calculator: directed and randomized requests checked against a predictor
`timescale 1ns / 100ps

module symbol_rate_register_calc_test;

	localparam int          RESET_CYCLES = 12;
	localparam int          DRAIN_CYCLES = 64;
	localparam int          LONG_HOLD    = 400;
	localparam int          WATCH_LIMIT  = 4000;
	localparam int          MAX_REPORTS  = 10;

	localparam logic [25:0] LOW_RATE     = 26'd500000;
	localparam logic [25:0] TOP_RATE     = 26'd46080000;
	localparam logic [25:0] SLOW_RATE    = 26'd6000000;
	localparam logic [63:0] CLOCK_IN     = 64'd5760000;
	localparam logic [7:0]  ADC_BYP_CODE = 8'h89;
	localparam logic [7:0]  ADC_FIL_CODE = 8'h81;
	localparam logic [7:0]  FILT_ON_CODE = 8'h88;
	localparam logic [7:0]  FILT_BYP     = 8'h80;
	localparam logic [7:0]  SLOW_FLAG    = 8'h80;
	localparam logic [7:0]  FAST_KEEP    = 8'h7f;
	localparam logic [63:0] INV_CEIL     = 64'd255;
	localparam logic [25:0] FILT_EDGE [10] = '{
		26'd11184810, 26'd7381975, 26'd5592405, 26'd3728270, 26'd2796202,
		26'd1845493, 26'd1398101, 26'd905969, 26'd699050, 26'd459695
	};

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [7:0]          cfg_wr_data = 8'd0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	srrc_pkg::in_item_t  in_data     = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	srrc_pkg::out_item_t out_data;

	srrc_pkg::in_item_t  pending_requests [$];
	srrc_pkg::out_item_t settings_due [$];

	logic [7:0]  rc_base      = 8'd43;
	logic [25:0] stored_rate  = 26'd0;
	logic [25:0] sent_rate    = 26'd0;
	logic        in_took      = 1'b0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          hold_ask      = 0;
	int          hold_done     = 0;
	int          hold_left     = 0;
	int          quiet_cycles  = 0;
	int          bad_results   = 0;

	symbol_rate_register_calc uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [25:0] clamp_rate(input logic [25:0] req);
		if (req > TOP_RATE)
			return TOP_RATE;
		if (req < LOW_RATE)
			return LOW_RATE;
		return req;
	endfunction

	// lowest rate whose ratio reaches the given filter limit
	function automatic logic [63:0] edge_rate(input logic [25:0] limit);
		return ({38'd0, limit} * CLOCK_IN + 64'd4194303) >> 22;
	endfunction

	function automatic srrc_pkg::out_item_t predict_settings(input srrc_pkg::in_item_t req);
		srrc_pkg::out_item_t r;
		logic [63:0]         rate;
		logic [63:0]         ratio;
		logic [63:0]         incr;
		logic [63:0]         inv;
		logic [3:0]          fnr;
		logic [2:0]          sh;
		logic                byp;
		r = '0;
		if (req.symbol_rate == stored_rate) begin
			r.clear_request = req.clear_if_same;
			return r;
		end
		stored_rate = clamp_rate(req.symbol_rate);
		rate = {38'd0, stored_rate};
		ratio = (rate << 22) / CLOCK_IN;
		fnr = 4'd0;
		byp = 1'b1;
		for (int i = 0; i < 10; i++) begin
			if (ratio < {38'd0, FILT_EDGE[i]}) begin
				fnr = 4'(i);
				byp = 1'b0;
			end
		end
		sh = 3'(fnr >> 1);
		incr = (((ratio << sh) >> 4) + 64'd1) >> 1;
		inv = (((CLOCK_IN << 8) / ((rate << sh) >> 2)) + 64'd1) >> 1;
		if (inv > INV_CEIL)
			inv = INV_CEIL;
		r.write_valid = 1'b1;
		r.clamped_rate = stored_rate;
		r.filter_number = fnr;
		r.bypass = byp;
		r.adc_setting = byp ? ADC_BYP_CODE : ADC_FIL_CODE;
		r.filter_setting = byp ? FILT_BYP : (FILT_ON_CODE | {5'd0, sh} | {2'd0, fnr[0], 5'd0});
		r.rate_control = (stored_rate < SLOW_RATE) ? (rc_base | SLOW_FLAG) : (rc_base & FAST_KEEP);
		r.baud_increment = incr[19:0];
		r.baud_inverse = inv[7:0];
		return r;
	endfunction

	function automatic string settings_text(input srrc_pkg::out_item_t r);
		return $sformatf("wv %0d clr %0d rate %0d fnr %0d byp %0d adc %h filt %h rc %h inc %h inv %h",
			r.write_valid, r.clear_request, r.clamped_rate, r.filter_number, r.bypass,
			r.adc_setting, r.filter_setting, r.rate_control, r.baud_increment, r.baud_inverse);
	endfunction

	task automatic push_request(input logic [25:0] rate, input logic clr);
		srrc_pkg::in_item_t it;
		it.symbol_rate = rate;
		it.clear_if_same = clr;
		if (rate != sent_rate)
			sent_rate = clamp_rate(rate);
		pending_requests.push_back(it);
	endtask

	task automatic push_random_requests(input int count);
		int          pick;
		logic [63:0] base;
		logic [31:0] raw;
		logic [25:0] rate;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			base = edge_rate(FILT_EDGE[$urandom_range(9)]);
			raw = $urandom();
			if (pick < 15)
				rate = sent_rate;
			else if (pick < 50)
				rate = 26'(base - 64'd3 + 64'($urandom_range(5)));
			else if (pick < 72)
				rate = 26'($urandom_range(16000000, 400000));
			else if (pick < 80)
				rate = SLOW_RATE - 26'd4 + 26'($urandom_range(7));
			else if (pick < 85)
				rate = LOW_RATE - 26'd4 + 26'($urandom_range(7));
			else if (pick < 90)
				rate = TOP_RATE - 26'd4 + 26'($urandom_range(7));
			else
				rate = raw[25:0];
			push_request(rate, 1'($urandom_range(1)));
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || settings_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate_control(input logic [7:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		rc_base = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sender
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_requests.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_ask != hold_done) begin
			hold_done <= hold_ask;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		srrc_pkg::out_item_t want;
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				settings_due.push_back(predict_settings(in_data));
			if (out_valid && !out_stall) begin
				if (settings_due.size() == 0) begin
					bad_results++;
					if (bad_results <= MAX_REPORTS)
						$display("unexpected item: %s", settings_text(out_data));
				end else begin
					want = settings_due.pop_front();
					if (out_data.write_valid !== want.write_valid
							|| out_data.clear_request !== want.clear_request
							|| out_data.clamped_rate !== want.clamped_rate
							|| out_data.filter_number !== want.filter_number
							|| out_data.bypass !== want.bypass
							|| out_data.adc_setting !== want.adc_setting
							|| out_data.filter_setting !== want.filter_setting
							|| out_data.rate_control !== want.rate_control
							|| out_data.baud_increment !== want.baud_increment
							|| out_data.baud_inverse !== want.baud_inverse) begin
						bad_results++;
						if (bad_results <= MAX_REPORTS)
							$display("mismatch at %0t\n  expected %s\n  actual   %s",
								$realtime, settings_text(want), settings_text(out_data));
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("FAIL symbol_rate_register_calc");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: unchanged zero, extremes, clamping, filter edges
		push_request(26'd0, 1'b1);
		push_request(26'h3FFFFFF, 1'b0);
		push_request(26'h3FFFFFF, 1'b1);
		push_request(TOP_RATE, 1'b1);
		push_request(26'd1, 1'b0);
		push_request(SLOW_RATE - 26'd1, 1'b0);
		for (int i = 0; i < 10; i++) begin
			push_request(26'(edge_rate(FILT_EDGE[i]) - 64'd1), 1'b0);
			push_request(26'(edge_rate(FILT_EDGE[i])), 1'b1);
		end
		wait_drained();

		write_rate_control(8'hFF);
		push_random_requests(350);
		wait_drained();

		write_rate_control(8'h00);
		send_idle_pct = 57;
		push_random_requests(350);
		wait_drained();

		write_rate_control(8'($urandom_range(255)));
		send_idle_pct = 0;
		stall_pct = 57;
		push_random_requests(350);
		wait_drained();

		write_rate_control(8'h80);
		send_idle_pct = 37;
		stall_pct = 37;
		push_random_requests(350);
		wait_drained();

		// back pressure: long receiver hold while the sender keeps offering
		write_rate_control(8'h7F);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_ask++;
		push_random_requests(300);
		wait_drained();

		if (bad_results == 0)
			$display("PASS symbol_rate_register_calc");
		else
			$display("FAIL symbol_rate_register_calc");
		$finish;
	end

endmodule

### symbol_rate_register_calc.f
hw/rtl/srrc_pkg.sv
hw/rtl/srrc_front.sv
hw/rtl/srrc_fifo.sv
hw/rtl/srrc_div.sv
hw/rtl/srrc_back.sv
hw/rtl/symbol_rate_register_calc.sv
bench/symbol_rate_register_calc_test.sv
